// ===== rtl/cpu_load_balance_decider_unit_macros.svh =====
// Assertion macros shared by the load balance decider RTL.
`ifndef CPU_LOAD_BALANCE_DECIDER_UNIT_MACROS_SVH
`define CPU_LOAD_BALANCE_DECIDER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CLBD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLBD_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define CLBD_ASSERT(name, clk, rst, prop, msg)
`define CLBD_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif
`endif

// ===== rtl/clbd_pkg.sv =====
`default_nettype none
package clbd_pkg;

  localparam int TOT_W      = 53;
  localparam int RT_W       = 48;
  localparam int ID_W       = 31;
  localparam int CPU_W      = 5;
  localparam int NUM_W      = 6;
  localparam int THR_W      = 7;
  localparam int DEC_W      = 3;
  localparam int CLS_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int PCT        = 100;

  localparam int MAX_CPU_SLOTS_DEF = 32;

  localparam logic [NUM_W-1:0] NUM_CPUS_RST  = 6'd4;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 7'd20;
  localparam logic [THR_W-1:0] THRESHOLD_MAX = 7'd99;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_EVAL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CPUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

  typedef enum logic [DEC_W-1:0] {
    DEC_MIGRATE    = 3'd0,
    DEC_FORCED     = 3'd1,
    DEC_BALANCED   = 3'd2,
    DEC_SMALL_GAIN = 3'd3,
    DEC_NO_TASK    = 3'd4
  } decision_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_LIGHT  = 2'd0,
    CLS_NORMAL = 2'd1,
    CLS_HEAVY  = 2'd2
  } cls_t;

  typedef struct packed {
    logic [TOT_W-1:0] total;
    logic [RT_W-1:0]  min_time;
    logic [ID_W-1:0]  min_pid;
    logic [ID_W-1:0]  min_tid;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/cpu_load_balance_decider_unit.sv =====
`default_nettype none
`include "cpu_load_balance_decider_unit_macros.svh"
// Per-CPU load collector and migration decider. A sample request (func 0) adds its run
// time to its CPU's total and keeps that CPU's shortest thread; samples whose cpu is at or
// above n are dropped. Samples go through a one-port-read, one-port-write RAM as a
// read-modify-write with forwarding, so one sample is taken every cycle while idle. An
// evaluate request (func 1) scans CPUs 1..n-1, one RAM read per cycle, then multiplies,
// classes and decides, where n is num_cpus held to 2..MAX_CPU_SLOTS; it holds input ready
// low from acceptance until its result is loaded, which waits for the previous result
// to be taken, and yields one result. Entry validity lives in flip-flops and is all cleared
// when the result is loaded, so no clearing pass is needed after reset or after an evaluate.
module cpu_load_balance_decider_unit import clbd_pkg::*; #(
  parameter int MAX_CPU_SLOTS = MAX_CPU_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  logic [CPU_W-1:0]      cpu,
  input  logic [RT_W-1:0]       run_time,
  input  logic [ID_W-1:0]       pid,
  input  logic [ID_W-1:0]       tid,
  input  logic                  force_move,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DEC_W-1:0]      decision,
  output logic [ID_W-1:0]       task_pid,
  output logic [ID_W-1:0]       task_tid,
  output logic [CPU_W-1:0]      target_cpu,
  output logic [CPU_W-1:0]      source_cpu,
  output logic [TOT_W-1:0]      min_load,
  output logic [TOT_W-1:0]      max_load,
  output logic [CLS_W-1:0]      min_class,
  output logic [CLS_W-1:0]      max_class
);

  localparam int IDX_W  = (MAX_CPU_SLOTS > 1) ? $clog2(MAX_CPU_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_CPU_SLOTS + 1);
  localparam int WIDE_W = (CNT_W > NUM_W) ? CNT_W : NUM_W;
  localparam int SUM_W  = TOT_W + IDX_W;
  localparam int M100_W = CNT_W + 7;
  localparam int PL_W   = TOT_W + M100_W;
  localparam int PS_W   = SUM_W + 8;
  localparam int PROD_W = (PL_W > PS_W) ? PL_W : PS_W;
  localparam int ENT_W  = $bits(entry_t);
  localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_CPU_SLOTS);
  localparam logic [WIDE_W-1:0] MIN_WIDE = WIDE_W'(2);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [NUM_W-1:0] num_cpus;
  logic [THR_W-1:0] threshold;

  logic [WIDE_W-1:0] num_wide;
  logic [WIDE_W-1:0] n_wide;
  logic [CNT_W-1:0]  n_cnt;
  logic [CNT_W-1:0]  m_cnt;
  logic [IDX_W-1:0]  m_idx;
  logic [THR_W-1:0]  thr_sat;
  logic [M100_W-1:0] m100;
  logic [7:0]        hi_mul;
  logic [6:0]        lo_mul;

  logic              accept;
  logic              cpu_ok;
  logic [IDX_W-1:0]  in_idx;

  // sample pipeline
  logic              s1_valid;
  logic [IDX_W-1:0]  s1_cpu;
  logic [RT_W-1:0]   s1_rt;
  logic [ID_W-1:0]   s1_pid;
  logic [ID_W-1:0]   s1_tid;

  // RAM and forwarding
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  rd_addr_q;
  logic [ENT_W-1:0]  rdata;
  entry_t            cur;
  logic              cur_present;
  entry_t            wr_data;
  logic              fwd_valid;
  logic [IDX_W-1:0]  fwd_addr;
  entry_t            fwd_data;
  logic [MAX_CPU_SLOTS-1:0] valid_vec;

  logic [TOT_W-1:0]  old_total;
  logic [TOT_W:0]    tot_sum;
  logic              replace;

  // scan
  logic [CNT_W-1:0]  issue_idx;
  logic              proc_valid;
  logic [IDX_W-1:0]  proc_idx;
  logic              first;
  logic              last;
  logic [TOT_W-1:0]  v;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [TOT_W-1:0]  min_q;
  logic [TOT_W-1:0]  max_q;
  logic [IDX_W-1:0]  min_idx;
  logic [IDX_W-1:0]  max_idx;
  entry_t            max_ent;
  logic              max_present;

  // evaluate request
  logic              e_force;
  logic [ID_W-1:0]   e_pid;
  logic [ID_W-1:0]   e_tid;

  // classify
  logic [PL_W-1:0]   prod_min;
  logic [PL_W-1:0]   prod_max;
  logic [PS_W-1:0]   prod_hi;
  logic [PS_W-1:0]   prod_lo;
  logic [PROD_W-1:0] p_min;
  logic [PROD_W-1:0] p_max;
  logic [PROD_W-1:0] p_hi;
  logic [PROD_W-1:0] p_lo;
  logic [TOT_W:0]    c_ext;
  logic              gain_small_next;
  logic              gain_small;
  cls_t              min_cls;
  cls_t              max_cls;
  cls_t              min_cls_next;
  cls_t              max_cls_next;
  logic              load_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;

  assign num_wide = WIDE_W'(num_cpus);
  assign n_wide   = (num_wide < MIN_WIDE) ? MIN_WIDE :
                    (num_wide > MAX_WIDE) ? MAX_WIDE : num_wide;
  assign n_cnt    = CNT_W'(n_wide);
  assign m_cnt    = n_cnt - CNT_W'(1);
  assign m_idx    = IDX_W'(m_cnt);
  assign thr_sat  = (threshold > THRESHOLD_MAX) ? THRESHOLD_MAX : threshold;
  assign m100     = M100_W'(m_cnt) * M100_W'(PCT);
  assign hi_mul   = 8'(PCT) + {1'b0, thr_sat};
  assign lo_mul   = 7'(PCT) - thr_sat;

  assign cpu_ok = WIDE_W'(cpu) < n_wide;
  assign in_idx = IDX_W'(cpu);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cpus  <= NUM_CPUS_RST;
      threshold <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_CPUS:  num_cpus  <= cfg_data[NUM_W-1:0];
        REG_THRESHOLD: threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- memory ----------------
  assign rd_addr = (state == ST_SCAN) ? issue_idx[IDX_W-1:0] : in_idx;

  clbd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_CPU_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_cpu),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign cur         = (fwd_valid && fwd_addr == rd_addr_q) ? fwd_data : entry_t'(rdata);
  assign cur_present = valid_vec[rd_addr_q];

  // sample read-modify-write
  assign old_total = cur_present ? cur.total : '0;
  assign replace   = !cur_present || (s1_rt < cur.min_time);
  assign tot_sum   = {1'b0, old_total} + (TOT_W+1)'(s1_rt);

  always_comb begin
    wr_data.total    = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
    wr_data.min_time = replace ? s1_rt  : cur.min_time;
    wr_data.min_pid  = replace ? s1_pid : cur.min_pid;
    wr_data.min_tid  = replace ? s1_tid : cur.min_tid;
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    fwd_addr  <= s1_cpu;
    fwd_data  <= wr_data;
    s1_cpu    <= in_idx;
    s1_rt     <= run_time;
    s1_pid    <= pid;
    s1_tid    <= tid;
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      valid_vec <= '0;
    end else begin
      s1_valid  <= accept && (func == FUNC_SAMPLE) && cpu_ok;
      fwd_valid <= s1_valid;
      if (load_out) begin
        valid_vec <= '0;
      end else if (s1_valid) begin
        valid_vec[s1_cpu] <= 1'b1;
      end
    end
  end

  // ---------------- scan ----------------
  assign first    = (proc_idx == IDX_W'(1));
  assign last     = (proc_idx == m_idx);
  assign v        = cur_present ? cur.total : '0;
  assign sum_next = (first ? '0 : sum) + SUM_W'(v);

  always_ff @(posedge clk) begin
    if (accept && func == FUNC_EVAL) begin
      e_force <= force_move;
      e_pid   <= pid;
      e_tid   <= tid;
    end
    if (state == ST_SCAN && proc_valid) begin
      sum <= sum_next;
      if (first || v < min_q) begin
        min_q   <= v;
        min_idx <= proc_idx;
      end
      if (first || v > max_q) begin
        max_q       <= v;
        max_idx     <= proc_idx;
        max_ent     <= cur;
        max_present <= cur_present;
      end
    end
  end

  // ---------------- classify ----------------
  assign prod_min = PL_W'(min_q) * PL_W'(m100);
  assign prod_max = PL_W'(max_q) * PL_W'(m100);
  assign prod_hi  = PS_W'(sum) * PS_W'(hi_mul);
  assign prod_lo  = PS_W'(sum) * PS_W'(lo_mul);
  assign c_ext    = (TOT_W+1)'(max_ent.min_time);
  assign gain_small_next = (c_ext > {1'b0, max_q}) ||
                           ({1'b0, min_q} + c_ext >= {1'b0, max_q} - c_ext);

  always_comb begin
    if (p_min > p_hi) begin
      min_cls_next = CLS_HEAVY;
    end else if (p_min < p_lo) begin
      min_cls_next = CLS_LIGHT;
    end else begin
      min_cls_next = CLS_NORMAL;
    end
    if (p_max > p_hi) begin
      max_cls_next = CLS_HEAVY;
    end else if (p_max < p_lo) begin
      max_cls_next = CLS_LIGHT;
    end else begin
      max_cls_next = CLS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      p_min      <= PROD_W'(prod_min);
      p_max      <= PROD_W'(prod_max);
      p_hi       <= PROD_W'(prod_hi);
      p_lo       <= PROD_W'(prod_lo);
      gain_small <= gain_small_next;
    end
    if (state == ST_CMP) begin
      min_cls <= min_cls_next;
      max_cls <= max_cls_next;
    end
  end

  // ---------------- control ----------------
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_idx  <= '0;
      proc_valid <= 1'b0;
      proc_idx   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          proc_valid <= 1'b0;
          issue_idx  <= CNT_W'(1);
          if (accept && func == FUNC_EVAL) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue_idx < n_cnt) begin
            proc_valid <= 1'b1;
            proc_idx   <= issue_idx[IDX_W-1:0];
            issue_idx  <= issue_idx + CNT_W'(1);
          end else begin
            proc_valid <= 1'b0;
          end
          if (proc_valid && last) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_CMP;
        ST_CMP: state <= ST_DONE;
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      target_cpu <= CPU_W'(min_idx);
      source_cpu <= CPU_W'(max_idx);
      min_load   <= min_q;
      max_load   <= max_q;
      min_class  <= min_cls;
      max_class  <= max_cls;
      if (e_force) begin
        decision <= DEC_FORCED;
        task_pid <= e_pid;
        task_tid <= e_tid;
      end else if (max_cls != CLS_HEAVY || min_cls != CLS_LIGHT) begin
        decision <= DEC_BALANCED;
        task_pid <= '0;
        task_tid <= '0;
      end else if (!max_present) begin
        decision <= DEC_NO_TASK;
        task_pid <= '0;
        task_tid <= '0;
      end else begin
        decision <= gain_small ? DEC_SMALL_GAIN : DEC_MIGRATE;
        task_pid <= max_ent.min_pid;
        task_tid <= max_ent.min_tid;
      end
    end
  end

  `CLBD_ASSERT(a_state_onehot, clk, rst, $onehot(state), "state is not one-hot")
  `CLBD_ASSERT(a_out_from_done, clk, rst,
               $rose(out_valid) |-> $past(state == ST_DONE), "result raised outside done")
  `CLBD_ASSERT_NEXT(a_clear_on_result, clk, rst, load_out, valid_vec == '0,
                    "store not cleared after evaluate")
  `CLBD_ASSERT(a_no_late_write, clk, rst,
               (s1_valid && state != ST_IDLE) |-> $past(state == ST_IDLE),
               "sample write during evaluate")

endmodule
`default_nettype wire

// ===== rtl/clbd_ram.sv =====
`default_nettype none
module clbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
module testbench import clbd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = MAX_CPU_SLOTS_DEF;
  localparam int SETTLE_CYCLES = MAX_CPU_SLOTS_DEF + 8;
  localparam int DRAIN_LIMIT = 100000;
  localparam int ROUND_ITEMS = 120;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic             kind;
    logic [CPU_W-1:0] core;
    logic [RT_W-1:0]  span;
    logic [ID_W-1:0]  proc_id;
    logic [ID_W-1:0]  thr_id;
    logic             forced;
  } lb_req_t;

  typedef struct packed {
    decision_t        verdict;
    logic [ID_W-1:0]  mv_pid;
    logic [ID_W-1:0]  mv_tid;
    logic [CPU_W-1:0] dst;
    logic [CPU_W-1:0] src;
    logic [TOT_W-1:0] lo_load;
    logic [TOT_W-1:0] hi_load;
    cls_t             lo_cls;
    cls_t             hi_cls;
  } move_rec_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  func = FUNC_SAMPLE;
  logic [CPU_W-1:0]      cpu = '0;
  logic [RT_W-1:0]       run_time = '0;
  logic [ID_W-1:0]       pid = '0;
  logic [ID_W-1:0]       tid = '0;
  logic                  force_move = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DEC_W-1:0]      decision;
  logic [ID_W-1:0]       task_pid;
  logic [ID_W-1:0]       task_tid;
  logic [CPU_W-1:0]      target_cpu;
  logic [CPU_W-1:0]      source_cpu;
  logic [TOT_W-1:0]      min_load;
  logic [TOT_W-1:0]      max_load;
  logic [CLS_W-1:0]      min_class;
  logic [CLS_W-1:0]      max_class;

  // shadow of the block's registers and per-CPU store
  logic [NUM_W-1:0] reg_ncpu = NUM_CPUS_RST;
  logic [THR_W-1:0] reg_thr = THRESHOLD_RST;
  logic [TOT_W-1:0] cpu_load [SLOTS];
  logic [RT_W-1:0]  short_span [SLOTS];
  logic [ID_W-1:0]  short_pid [SLOTS];
  logic [ID_W-1:0]  short_tid [SLOTS];
  logic             has_task [SLOTS];

  move_rec_t expected_moves[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int phase_no = 0;

  cpu_load_balance_decider_unit u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .cpu(cpu), .run_time(run_time),
    .pid(pid), .tid(tid), .force_move(force_move),
    .out_valid(out_valid), .out_ready(out_ready), .decision(decision),
    .task_pid(task_pid), .task_tid(task_tid), .target_cpu(target_cpu),
    .source_cpu(source_cpu), .min_load(min_load), .max_load(max_load),
    .min_class(min_class), .max_class(max_class)
  );

  always #1 clk = ~clk;

  function automatic int active_cpus();
    if (reg_ncpu < 2) return 2;
    if (reg_ncpu > SLOTS) return SLOTS;
    return int'(reg_ncpu);
  endfunction

  function automatic cls_t load_class(logic [TOT_W-1:0] load, logic [63:0] total, int m, int t);
    logic [79:0] lhs, heavy_bar, light_bar;
    lhs = 80'(load) * 80'(m * PCT);
    heavy_bar = 80'(total) * 80'(PCT + t);
    light_bar = 80'(total) * 80'(PCT - t);
    if (lhs > heavy_bar) return CLS_HEAVY;
    if (lhs < light_bar) return CLS_LIGHT;
    return CLS_NORMAL;
  endfunction

  task automatic clear_samples();
    for (int i = 0; i < SLOTS; i++) begin
      cpu_load[i] = '0;
      short_span[i] = '0;
      short_pid[i] = '0;
      short_tid[i] = '0;
      has_task[i] = 1'b0;
    end
  endtask

  task automatic record_sample(input lb_req_t r);
    logic [TOT_W:0] acc;
    if (r.core >= active_cpus()) return;
    if (!has_task[r.core] || r.span < short_span[r.core]) begin
      has_task[r.core] = 1'b1;
      short_span[r.core] = r.span;
      short_pid[r.core] = r.proc_id;
      short_tid[r.core] = r.thr_id;
    end
    acc = {1'b0, cpu_load[r.core]} + (TOT_W+1)'(r.span);
    cpu_load[r.core] = acc[TOT_W] ? {TOT_W{1'b1}} : acc[TOT_W-1:0];
  endtask

  task automatic decide_move(input lb_req_t r);
    int n, m, t, lo_i, hi_i;
    logic [63:0] total_sum, c64;
    logic [TOT_W-1:0] lo_v, hi_v;
    move_rec_t mv;
    n = active_cpus();
    m = n - 1;
    t = int'((reg_thr > THRESHOLD_MAX) ? THRESHOLD_MAX : reg_thr);
    total_sum = '0;
    lo_v = '0;
    hi_v = '0;
    lo_i = 1;
    hi_i = 1;
    for (int i = 1; i < n; i++) begin
      total_sum = total_sum + 64'(cpu_load[i]);
      if (i == 1 || cpu_load[i] < lo_v) begin
        lo_v = cpu_load[i];
        lo_i = i;
      end
      if (i == 1 || cpu_load[i] > hi_v) begin
        hi_v = cpu_load[i];
        hi_i = i;
      end
    end
    mv.lo_cls = load_class(lo_v, total_sum, m, t);
    mv.hi_cls = load_class(hi_v, total_sum, m, t);
    mv.mv_pid = '0;
    mv.mv_tid = '0;
    if (r.forced) begin
      mv.verdict = DEC_FORCED;
      mv.mv_pid = r.proc_id;
      mv.mv_tid = r.thr_id;
    end else if (mv.hi_cls != CLS_HEAVY || mv.lo_cls != CLS_LIGHT) begin
      mv.verdict = DEC_BALANCED;
    end else if (!has_task[hi_i]) begin
      mv.verdict = DEC_NO_TASK;
    end else begin
      c64 = 64'(short_span[hi_i]);
      mv.mv_pid = short_pid[hi_i];
      mv.mv_tid = short_tid[hi_i];
      if (c64 > hi_v || 64'(lo_v) + c64 >= 64'(hi_v) - c64) mv.verdict = DEC_SMALL_GAIN;
      else mv.verdict = DEC_MIGRATE;
    end
    mv.dst = CPU_W'(lo_i);
    mv.src = CPU_W'(hi_i);
    mv.lo_load = lo_v;
    mv.hi_load = hi_v;
    expected_moves.push_back(mv);
    clear_samples();
  endtask

  task automatic log_mismatch(input string why, input move_rec_t want, input move_rec_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $realtime, why);
      $display("  exp dec=%0d pid=%h tid=%h dst=%0d src=%0d lo=%h hi=%h cls=%0d/%0d",
               want.verdict, want.mv_pid, want.mv_tid, want.dst, want.src,
               want.lo_load, want.hi_load, want.lo_cls, want.hi_cls);
      $display("  got dec=%0d pid=%h tid=%h dst=%0d src=%0d lo=%h hi=%h cls=%0d/%0d",
               got.verdict, got.mv_pid, got.mv_tid, got.dst, got.src,
               got.lo_load, got.hi_load, got.lo_cls, got.hi_cls);
    end
  endtask

  always @(posedge clk) begin : check_moves
    move_rec_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.verdict = decision_t'(decision);
      got.mv_pid = task_pid;
      got.mv_tid = task_tid;
      got.dst = target_cpu;
      got.src = source_cpu;
      got.lo_load = min_load;
      got.hi_load = max_load;
      got.lo_cls = cls_t'(min_class);
      got.hi_cls = cls_t'(max_class);
      if (expected_moves.size() == 0) begin
        log_mismatch("result with no request pending", '0, got);
      end else begin
        want = expected_moves.pop_front();
        if (got.verdict !== want.verdict || got.mv_pid !== want.mv_pid ||
            got.mv_tid !== want.mv_tid || got.dst !== want.dst || got.src !== want.src ||
            got.lo_load !== want.lo_load || got.hi_load !== want.hi_load ||
            got.lo_cls !== want.lo_cls || got.hi_cls !== want.hi_cls)
          log_mismatch("result mismatch", want, got);
      end
    end
  end

  // result side: random stalls plus an optional long hold
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // leaves in_valid high; callers lower it through wait_drained
  task automatic send_req(input lb_req_t r);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    func <= r.kind;
    cpu <= r.core;
    run_time <= r.span;
    pid <= r.proc_id;
    tid <= r.thr_id;
    force_move <= r.forced;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (r.kind == FUNC_EVAL) decide_move(r);
    else record_sample(r);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [CPU_W-1:0] core, input logic [RT_W-1:0] span,
                             input logic [ID_W-1:0] p, input logic [ID_W-1:0] t);
    lb_req_t r;
    r = '{kind: FUNC_SAMPLE, core: core, span: span, proc_id: p, thr_id: t, forced: 1'b0};
    send_req(r);
  endtask

  task automatic send_evaluate(input logic forced, input logic [ID_W-1:0] p,
                               input logic [ID_W-1:0] t);
    lb_req_t r;
    r = '{kind: FUNC_EVAL, core: '0, span: '0, proc_id: p, thr_id: t, forced: forced};
    send_req(r);
  endtask

  task automatic wait_drained();
    int cnt;
    cnt = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      cnt++;
    end while (expected_moves.size() != 0 && cnt < DRAIN_LIMIT);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NUM_CPUS) reg_ncpu = data[NUM_W-1:0];
    else if (idx == REG_THRESHOLD) reg_thr = data[THR_W-1:0];
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] ncpu,
                              input logic [CFG_DATA_W-1:0] thr);
    wait_idle();
    cfg_write(REG_NUM_CPUS, ncpu);
    cfg_write(REG_THRESHOLD, thr);
    if (phase_no == 0) cfg_write(REG_SPARE, CFG_DATA_W'($urandom_range(127)));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RT_W-1:0] rand_span();
    int pick;
    logic [63:0] raw;
    pick = $urandom_range(99);
    raw = {$urandom, $urandom};
    if (pick < 25) return RT_W'($urandom_range(15));
    if (pick < 60) return RT_W'($urandom_range(4095));
    if (pick < 75) return raw[RT_W-1:0];
    if (pick < 80) return '1;
    return RT_W'($urandom_range(1 << 20));
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return '1;
    if (pick < 16) return '0;
    return ID_W'($urandom);
  endfunction

  // one collection window: samples (many on one busy CPU) closed by an evaluate
  task automatic send_round(input int samples);
    int n, busy, pick;
    lb_req_t r;
    n = active_cpus();
    busy = $urandom_range(n - 1, 1);
    repeat (samples) begin
      pick = $urandom_range(99);
      r.kind = FUNC_SAMPLE;
      if (pick < 10) r.core = CPU_W'($urandom_range(31));
      else if (pick < 50) r.core = CPU_W'(busy);
      else r.core = CPU_W'($urandom_range(n - 1));
      r.span = rand_span();
      r.proc_id = rand_id();
      r.thr_id = rand_id();
      r.forced = 1'($urandom_range(1));
      send_req(r);
    end
    r.kind = FUNC_EVAL;
    r.core = CPU_W'($urandom_range(31));
    r.span = rand_span();
    r.proc_id = rand_id();
    r.thr_id = rand_id();
    r.forced = ($urandom_range(99) < 15);
    send_req(r);
  endtask

  task automatic test_directed();
    send_evaluate(1'b0, '1, '1);
    send_sample(5'd4, 48'd77, 31'd1, 31'd1);
    send_sample(5'd31, '1, '1, '1);
    send_sample(5'd0, '1, 31'd5, 31'd5);
    send_sample(5'd2, 48'd10, 31'd100, 31'd101);
    send_sample(5'd2, 48'd10, 31'd200, 31'd201);
    send_sample(5'd2, 48'd100, 31'd300, 31'd301);
    send_sample(5'd3, 48'd50, 31'd400, 31'd401);
    send_evaluate(1'b0, '0, '0);
    send_evaluate(1'b1, '1, '1);
    send_sample(5'd1, '0, '0, '0);
    send_sample(5'd3, 48'd5, 31'd7, 31'd8);
    send_evaluate(1'b0, '0, '0);
    send_sample(5'd1, '1, '1, '1);
    send_sample(5'd2, '1, 31'd1, 31'd2);
    send_sample(5'd3, '1, 31'd3, 31'd4);
    send_evaluate(1'b0, '0, '0);
    send_sample(5'd3, 48'd1, '1, '0);
    send_evaluate(1'b1, '0, '1);
    wait_drained();
  endtask

  task automatic test_total_saturation();
    repeat (34) send_sample(5'd1, '1, rand_id(), rand_id());
    repeat (5) send_sample(5'd2, RT_W'($urandom_range(1000)), rand_id(), rand_id());
    send_evaluate(1'b0, '0, '0);
    repeat (33) send_sample(5'd2, '1, rand_id(), rand_id());
    repeat (33) send_sample(5'd3, '1, rand_id(), rand_id());
    send_evaluate(1'b0, '0, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int s_pct, input int r_pct);
    int sent, k;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (3) begin
      case (phase_no)
        0: program_regs(7'd0, 7'd127);
        1: program_regs(7'd63, 7'd0);
        2: program_regs(7'd2, 7'd99);
        3: program_regs(7'd100, 7'd100);
        4: program_regs(7'd1, 7'd50);
        5: program_regs(7'd32, 7'd5);
        7: program_regs(7'd33, 7'd20);
        default: program_regs(CFG_DATA_W'($urandom_range(63)),
                              CFG_DATA_W'($urandom_range(127)));
      endcase
      sent = 0;
      while (sent < ROUND_ITEMS) begin
        k = $urandom_range(24);
        send_round(k);
        sent += k + 1;
      end
      phase_no++;
    end
    wait_drained();
  endtask

  // hold the result side long enough that a second evaluate backs up the input
  task automatic test_stall_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_cycles = 400;
    @(negedge clk);
    repeat (4) send_round($urandom_range(12, 2));
    wait_drained();
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    repeat (4) begin
      send_round($urandom_range(10, 1));
      wait_drained();
    end
  endtask

  initial begin
    clear_samples();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 22;
    recv_idle_pct = 49;
    test_directed();
    test_total_saturation();
    test_random_traffic(22, 49);
    test_random_traffic(49, 22);
    test_random_traffic(0, 0);
    test_stall_fill();
    test_drain_pause();
    wait_idle();
    if (expected_moves.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_moves.size());
    end
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
